### rtl/hlc_pkg.sv
package hlc_pkg;

  localparam logic [1:0] MODE_ADD      = 2'd0;
  localparam logic [1:0] MODE_GET      = 2'd1;
  localparam logic [1:0] MODE_CONTAINS = 2'd2;
  localparam logic [1:0] MODE_EVICT    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NO_OBJECT = 2'd2;

  localparam int NUM_BUCKETS = 'hff + 1;

  // search token walking down the cell row
  typedef struct packed {
    logic        live;
    logic        found;
    logic [31:0] payload;
  } tok_t;

  // broadcast update applied by all cells at once
  typedef struct packed {
    logic       apply;
    logic [1:0] op;
  } cmd_t;

endpackage

### rtl/hashed_lru_id_cache_top.sv
// Bucketed LRU key cache. A request is taken when start is high and busy is low;
// its single result appears for one cycle with done high and cannot be stalled.
// Add, get and contains finish when the search token has walked the row of slot
// cells, one cell per cycle. Evict first sweeps the 256 bucket counters in the
// count RAM, one per cycle, and then walks the row. An add over the limit or an
// evict of an empty cache answers in the cycle after the request is taken.
// Recency is a unique age rank per slot, updated in all cells at once when the
// walk finishes.
module hashed_lru_id_cache_top import hlc_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [63:0] key_high,
  input  logic [63:0] key_mid,
  input  logic [31:0] key_low,
  input  logic [31:0] payload,
  output logic        done,
  output logic [1:0]  status,
  output logic        hit,
  output logic [31:0] out_payload,
  output logic [6:0]  entry_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW = $clog2(CAPACITY);
  localparam int TW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_BSCAN  = 2'd1;
  localparam logic [1:0] S_BDRAIN = 2'd2;
  localparam logic [1:0] S_CHAIN  = 2'd3;

  logic [1:0]  state;
  logic [6:0]  max_entries;
  logic [1:0]  mode_r;
  logic [63:0] kh_r;
  logic [63:0] km_r;
  logic [31:0] kl_r;
  logic [31:0] pl_r;
  logic [TW-1:0] total;
  logic        inj;

  logic [7:0]    bcnt;
  logic [7:0]    addr_d;
  logic          cmp_v;
  logic [TW-1:0] most;
  logic [7:0]    idx;
  logic [NUM_BUCKETS-1:0] bvalid;
  logic          bv_q;
  logic [TW-1:0] ram_q;
  logic [TW-1:0] bval;
  logic [7:0]    rd_addr;
  logic          ram_we;
  logic [7:0]    wr_addr;
  logic [TW-1:0] wr_data;

  tok_t          tok_c  [CAPACITY+1];
  logic [RW-1:0] rank_c [CAPACITY+1];
  cmd_t          cmd;
  tok_t          tok_end;
  logic          chain_end;
  logic          full;
  logic [TW-1:0] total_n;
  logic [TW+6:0] tot_ext;
  logic [TW+6:0] cur_ext;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {25'd0, max_entries} : 32'd0;
  assign busy   = state != S_IDLE;

  assign tok_c[0].live    = inj;
  assign tok_c[0].found   = 1'b0;
  assign tok_c[0].payload = 32'd0;
  assign rank_c[0]        = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    hlc_cell #(.RW(RW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .mode     (mode_r),
      .key_high (kh_r),
      .key_mid  (km_r),
      .key_low  (kl_r),
      .payload  (pl_r),
      .bucket   (idx),
      .tok_in   (tok_c[i]),
      .rank_in  (rank_c[i]),
      .cmd      (cmd),
      .cmd_rank (rank_c[CAPACITY]),
      .tok_out  (tok_c[i+1]),
      .rank_out (rank_c[i+1])
    );
  end

  hlc_ram #(.WIDTH(TW), .DEPTH(NUM_BUCKETS)) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_comb begin
    tok_end   = tok_c[CAPACITY];
    chain_end = (state == S_CHAIN) && tok_end.live;
    cmd.op    = mode_r;
    cmd.apply = chain_end && (mode_r == MODE_ADD ||
                (tok_end.found && (mode_r == MODE_GET || mode_r == MODE_EVICT)));
    bval      = bv_q ? ram_q : '0;
    rd_addr   = (state == S_BSCAN) ? bcnt : kh_r[63:56];
    ram_we    = chain_end && (mode_r == MODE_ADD || mode_r == MODE_EVICT);
    wr_addr   = (mode_r == MODE_EVICT) ? idx : kh_r[63:56];
    wr_data   = (mode_r == MODE_EVICT) ? most - 1'b1 : bval + 1'b1;
    full      = ({7'd0, total} >= {{(TW){1'b0}}, max_entries}) ||
                (total >= TW'(CAPACITY));
    total_n   = total;
    if (mode_r == MODE_ADD) begin
      total_n = total + 1'b1;
    end else if (mode_r == MODE_EVICT) begin
      total_n = total - 1'b1;
    end
    tot_ext   = {7'd0, total_n};
    cur_ext   = {7'd0, total};
  end

  always_ff @(posedge clk) begin
    bv_q   <= bvalid[rd_addr];
    addr_d <= bcnt;
    if (start && !busy) begin
      mode_r <= mode;
      kh_r   <= key_high;
      km_r   <= key_mid;
      kl_r   <= key_low;
      pl_r   <= payload;
    end
    if (rst) begin
      state       <= S_IDLE;
      max_entries <= 7'd64;
      total       <= '0;
      inj         <= 1'b0;
      done        <= 1'b0;
      cmp_v       <= 1'b0;
      bvalid      <= '0;
    end else begin
      inj  <= 1'b0;
      done <= 1'b0;
      if (psel && penable && pwrite && pready && paddr == 3'd0) begin
        max_entries <= pwdata[6:0];
      end
      if (ram_we) begin
        bvalid[wr_addr] <= 1'b1;
      end
      if (cmp_v && bval > most) begin
        most <= bval;
        idx  <= addr_d;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            if (mode == MODE_ADD && full) begin
              done        <= 1'b1;
              status      <= ST_NO_SPACE;
              hit         <= 1'b0;
              out_payload <= 32'd0;
              entry_count <= cur_ext[6:0];
            end else if (mode == MODE_EVICT && total == '0) begin
              done        <= 1'b1;
              status      <= ST_NO_OBJECT;
              hit         <= 1'b0;
              out_payload <= 32'd0;
              entry_count <= 7'd0;
            end else if (mode == MODE_EVICT) begin
              state <= S_BSCAN;
              bcnt  <= 8'd0;
              cmp_v <= 1'b0;
              most  <= '0;
              idx   <= 8'd0;
            end else begin
              state <= S_CHAIN;
              inj   <= 1'b1;
            end
          end
        end
        S_BSCAN: begin
          bcnt  <= bcnt + 1'b1;
          cmp_v <= 1'b1;
          if (bcnt == 8'(NUM_BUCKETS - 1)) begin
            state <= S_BDRAIN;
          end
        end
        S_BDRAIN: begin
          cmp_v <= 1'b0;
          inj   <= 1'b1;
          state <= S_CHAIN;
        end
        S_CHAIN: begin
          if (tok_end.live) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            status      <= ST_OK;
            hit         <= tok_end.found &&
                           (mode_r == MODE_GET || mode_r == MODE_CONTAINS);
            out_payload <= (tok_end.found &&
                           (mode_r == MODE_GET || mode_r == MODE_EVICT)) ?
                           tok_end.payload : 32'd0;
            if (mode_r == MODE_ADD || mode_r == MODE_EVICT) begin
              total       <= total_n;
              entry_count <= tot_ext[6:0];
            end else begin
              entry_count <= tot_ext[6:0];
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/hlc_ram.sv
module hlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/hlc_cell.sv
module hlc_cell import hlc_pkg::*; #(
  parameter int RW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    mode,
  input  logic [63:0]   key_high,
  input  logic [63:0]   key_mid,
  input  logic [31:0]   key_low,
  input  logic [31:0]   payload,
  input  logic [7:0]    bucket,
  input  tok_t          tok_in,
  input  logic [RW-1:0] rank_in,
  input  cmd_t          cmd,
  input  logic [RW-1:0] cmd_rank,
  output tok_t          tok_out,
  output logic [RW-1:0] rank_out
);

  logic          valid;
  logic          pending;
  logic [63:0]   kh;
  logic [63:0]   km;
  logic [31:0]   kl;
  logic [31:0]   pl;
  logic [RW-1:0] rank;

  logic match, cand, take, claim;
  tok_t tok_next;
  logic [RW-1:0] rank_next;

  always_comb begin
    match = valid && kh == key_high && km == key_mid && kl == key_low;
    cand  = valid && kh[63:56] == bucket;
    take  = 1'b0;
    claim = 1'b0;
    case (mode)
      MODE_ADD: begin
        claim = tok_in.live && !tok_in.found && !valid && !pending;
      end
      MODE_GET, MODE_CONTAINS: begin
        take = tok_in.live && match && (!tok_in.found || rank < rank_in);
      end
      MODE_EVICT: begin
        take = tok_in.live && cand && (!tok_in.found || rank > rank_in);
      end
      default: begin
        take = 1'b0;
      end
    endcase
    tok_next.live    = tok_in.live;
    tok_next.found   = tok_in.found | take | claim;
    tok_next.payload = take ? pl : tok_in.payload;
    rank_next        = take ? rank : rank_in;
  end

  always_ff @(posedge clk) begin
    tok_out.found   <= tok_next.found;
    tok_out.payload <= tok_next.payload;
    rank_out        <= rank_next;
    if (claim) begin
      kh <= key_high;
      km <= key_mid;
      kl <= key_low;
      pl <= payload;
    end
    if (cmd.apply) begin
      case (cmd.op)
        MODE_ADD: begin
          if (valid) begin
            rank <= rank + 1'b1;
          end else if (pending) begin
            rank <= '0;
          end
        end
        MODE_GET: begin
          if (valid && rank < cmd_rank) begin
            rank <= rank + 1'b1;
          end else if (valid && rank == cmd_rank) begin
            rank <= '0;
          end
        end
        MODE_EVICT: begin
          if (valid && rank > cmd_rank) begin
            rank <= rank - 1'b1;
          end
        end
        default: begin
          rank <= rank;
        end
      endcase
    end
    if (rst) begin
      tok_out.live <= 1'b0;
      valid        <= 1'b0;
      pending      <= 1'b0;
    end else begin
      tok_out.live <= tok_next.live;
      if (claim) begin
        pending <= 1'b1;
      end
      if (cmd.apply && cmd.op == MODE_ADD && pending) begin
        valid   <= 1'b1;
        pending <= 1'b0;
      end
      if (cmd.apply && cmd.op == MODE_EVICT && valid && rank == cmd_rank) begin
        valid <= 1'b0;
      end
    end
  end

endmodule
